FILE: hdl/tpoc_pkg.sv
// Shared types and constants for the timer pool with owner credit.
package tpoc_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int OWNER_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [30:0]        MAX31   = 31'h7FFF_FFFF;
  localparam logic signed [32:0] MAX31_S = 33'sh0_7FFF_FFFF;

  // request codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_ARM   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_SETCR = 3'd3;
  localparam logic [2:0] FUNC_RDCR  = 3'd4;

  typedef enum logic [3:0] {
    KIND_EXPIRED   = 4'd0,
    KIND_FIRED     = 4'd1,
    KIND_ARMED     = 4'd2,
    KIND_FULL      = 4'd3,
    KIND_CLEARED   = 4'd4,
    KIND_NOT_FOUND = 4'd5,
    KIND_CREDIT    = 4'd6,
    KIND_NO_CREDIT = 4'd7,
    KIND_DONE      = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ALU_TICK,   // amount - remaining
    ALU_DUR,    // amount - carry
    ALU_DCR,    // duration - credit
    ALU_CRD,    // credit - duration
    ALU_NEG     // 0 - duration
  } alu_op_t;

  typedef struct packed {
    logic signed [32:0] diff;
    logic               neg;
    logic               over31;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_ARM_DUR,
    ST_ARM_CR,
    ST_ARM_LEFT,
    ST_ARM_CHK,
    ST_ARM_FIND,
    ST_CLR,
    ST_SETC,
    ST_RDC_A,
    ST_RDC_B,
    ST_DFLT
  } state_t;

endpackage

FILE: hdl/tpoc_alu.sv
// Shared subtractor with operand selection and range flags.
module tpoc_alu (
  input  tpoc_pkg::alu_op_t  op,
  input  logic [30:0]        amount,
  input  logic [30:0]        carry,
  input  logic signed [31:0] acc,
  input  logic [30:0]        rem,
  input  logic [30:0]        crd,
  output tpoc_pkg::alu_res_t res
);
  import tpoc_pkg::*;

  logic signed [32:0] a_op;
  logic signed [32:0] b_op;
  logic signed [32:0] acc_x;
  logic signed [32:0] diff;

  assign acc_x = {acc[31], acc};

  always_comb begin
    unique case (op)
      ALU_TICK: begin
        a_op = {2'b00, amount};
        b_op = {2'b00, rem};
      end
      ALU_DUR: begin
        a_op = {2'b00, amount};
        b_op = {2'b00, carry};
      end
      ALU_DCR: begin
        a_op = acc_x;
        b_op = {2'b00, crd};
      end
      ALU_CRD: begin
        a_op = {2'b00, crd};
        b_op = acc_x;
      end
      ALU_NEG: begin
        a_op = '0;
        b_op = acc_x;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign diff       = a_op - b_op;
  assign res.diff   = diff;
  assign res.neg    = diff[32];
  assign res.over31 = (diff > MAX31_S);

endmodule

FILE: hdl/timer_pool_with_owner_credit_top.sv
// Top level of the timer pool with owner credit: sequencer, slot and credit stores.
//
// A request is taken when start is high and busy is low; busy stays high until the
// request's last result has been produced. Results are registered and appear in the
// cycle after they are formed, each on the out_ ports for a single cycle with
// out_valid high, and the receiver cannot stall them. A tick walks every slot in
// descending order through the read port of the slot memory, one slot a cycle. A
// clear walks the slots upward the same way and stops at the first match. An arm
// forms the duration and applies any credit through the single shared subtractor,
// then examines one slot a cycle in the free-slot search, which stops at the first
// free slot or reports the pool full. An arm that fires at once skips the search.
module timer_pool_with_owner_credit_top #(
  parameter int TIMER_SLOTS = tpoc_pkg::TIMER_SLOTS_DEF,
  parameter int OWNER_SLOTS = tpoc_pkg::OWNER_SLOTS_DEF,
  parameter int ID_BITS     = tpoc_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [30:0] in_amount,
  input  logic [30:0] in_carry_in,
  input  logic        in_owner_valid,
  input  logic [3:0]  in_owner,
  input  logic [15:0] in_timer_id,
  output logic        out_valid,
  output logic [3:0]  out_kind,
  output logic [15:0] out_result_id,
  output logic [30:0] out_overshoot,
  output logic [30:0] out_credit_value,
  output logic        out_last
);
  import tpoc_pkg::*;

  localparam int SA = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int OA = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam logic [SA-1:0] LAST_SLOT = SA'(TIMER_SLOTS - 1);

  // sequencer state
  state_t state_r, state_nxt;
  logic [SA-1:0] scan_r, scan_nxt;
  logic issue_r, issue_nxt;
  logic pend_r, pend_nxt;
  logic [SA-1:0] pidx_r, pidx_nxt;
  logic wb_en_r, wb_en_nxt;
  logic [SA-1:0] wb_idx_r, wb_idx_nxt;
  logic signed [32:0] wb_d_r, wb_d_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic [TIMER_SLOTS-1:0] live_r, live_nxt;
  logic [OWNER_SLOTS-1:0] present_r, present_nxt;

  // captured request
  logic [30:0]        amount_r;
  logic [30:0]        carry_r;
  logic               ownv_r;
  logic [OA-1:0]      own_idx_r;
  logic               own_ok_r;
  logic [ID_BITS-1:0] tid_r;

  // memories
  logic [30:0]        rem_mem [TIMER_SLOTS];
  logic [ID_BITS-1:0] id_mem  [TIMER_SLOTS];
  logic [30:0]        cr_mem  [OWNER_SLOTS];
  logic [30:0]        rd_rem_r;
  logic [ID_BITS-1:0] rd_id_r;
  logic [30:0]        rd_cr_r;
  logic               rem_we;
  logic [SA-1:0]      rem_wa;
  logic [30:0]        rem_wd;
  logic               id_we;
  logic               cr_we;
  logic [30:0]        cr_wd;

  // result formed this cycle
  logic        e_valid;
  kind_t       e_kind;
  logic [15:0] e_id;
  logic [30:0] e_over;
  logic [30:0] e_cred;
  logic        e_last;

  // output registers
  logic        out_valid_r;
  logic [3:0]  out_kind_r;
  logic [15:0] out_result_id_r;
  logic [30:0] out_overshoot_r;
  logic [30:0] out_credit_value_r;
  logic        out_last_r;

  alu_op_t  alu_op;
  alu_res_t alu_res;

  logic        accept;
  logic [8:0]  own_x;
  logic [31:0] tid_x;
  logic [31:0] tid_r_x;
  logic [31:0] rd_id_x;
  logic [31:0] next_id_x;
  logic signed [32:0] wb_neg;
  logic        has_cr;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign own_x   = 9'(in_owner);
  assign tid_x   = 32'(in_timer_id);
  assign tid_r_x = 32'(tid_r);
  assign rd_id_x = 32'(rd_id_r);
  assign next_id_x = 32'(next_id_r);
  assign wb_neg  = -wb_d_r;
  assign has_cr  = ownv_r && own_ok_r && present_r[own_idx_r];

  tpoc_alu u_alu (
    .op     (alu_op),
    .amount (amount_r),
    .carry  (carry_r),
    .acc    (acc_r),
    .rem    (rd_rem_r),
    .crd    (rd_cr_r),
    .res    (alu_res)
  );

  always_comb begin
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    issue_nxt   = issue_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    wb_en_nxt   = 1'b0;
    wb_idx_nxt  = wb_idx_r;
    wb_d_nxt    = wb_d_r;
    acc_nxt     = acc_r;
    next_id_nxt = next_id_r;
    live_nxt    = live_r;
    present_nxt = present_r;
    alu_op      = ALU_DUR;
    rem_we      = 1'b0;
    rem_wa      = pidx_r;
    rem_wd      = acc_r[30:0];
    id_we       = 1'b0;
    cr_we       = 1'b0;
    cr_wd       = amount_r;
    e_valid     = 1'b0;
    e_kind      = KIND_DONE;
    e_id        = '0;
    e_over      = '0;
    e_cred      = '0;
    e_last      = 1'b1;

    // finish a pending remaining-time write from the tick walk
    if (wb_en_r) begin
      rem_we = 1'b1;
      rem_wa = wb_idx_r;
      rem_wd = wb_neg[30:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pend_nxt = 1'b0;
          unique case (in_func)
            FUNC_TICK: begin
              state_nxt = ST_TICK;
              scan_nxt  = LAST_SLOT;
              issue_nxt = 1'b1;
            end
            FUNC_ARM:   state_nxt = ST_ARM_DUR;
            FUNC_CLEAR: begin
              state_nxt = ST_CLR;
              scan_nxt  = '0;
              issue_nxt = 1'b1;
            end
            FUNC_SETCR: state_nxt = ST_SETC;
            FUNC_RDCR:  state_nxt = ST_RDC_A;
            default:    state_nxt = ST_DFLT;
          endcase
        end
      end

      ST_TICK: begin
        alu_op = ALU_TICK;
        if (pend_r && live_r[pidx_r]) begin
          if (!alu_res.neg) begin
            e_valid          = 1'b1;
            e_kind           = KIND_EXPIRED;
            e_id             = rd_id_x[15:0];
            e_over           = alu_res.diff[30:0];
            e_last           = 1'b0;
            live_nxt[pidx_r] = 1'b0;
          end else begin
            wb_en_nxt  = 1'b1;
            wb_idx_nxt = pidx_r;
            wb_d_nxt   = alu_res.diff;
          end
        end
        pend_nxt = issue_r;
        pidx_nxt = scan_r;
        if (issue_r) begin
          if (scan_r == '0) issue_nxt = 1'b0;
          else scan_nxt = scan_r - 1'b1;
        end
        if (!issue_r && !pend_r) begin
          e_valid   = 1'b1;
          e_kind    = KIND_DONE;
          state_nxt = ST_IDLE;
        end
      end

      ST_ARM_DUR: begin
        alu_op    = ALU_DUR;
        acc_nxt   = alu_res.diff[31:0];
        state_nxt = ST_ARM_CR;
      end

      ST_ARM_CR: begin
        alu_op = ALU_DCR;
        if (!has_cr) begin
          state_nxt = ST_ARM_CHK;
        end else if (!alu_res.neg) begin
          acc_nxt                = alu_res.diff[31:0];
          present_nxt[own_idx_r] = 1'b0;
          state_nxt              = ST_ARM_CHK;
        end else begin
          state_nxt = ST_ARM_LEFT;
        end
      end

      ST_ARM_LEFT: begin
        // credit outlasts the duration: shrink it and fire now
        alu_op    = ALU_CRD;
        cr_we     = 1'b1;
        cr_wd     = alu_res.over31 ? MAX31 : alu_res.diff[30:0];
        e_valid   = 1'b1;
        e_kind    = KIND_FIRED;
        state_nxt = ST_IDLE;
      end

      ST_ARM_CHK: begin
        alu_op = ALU_NEG;
        if (acc_r[31]) begin
          e_valid   = 1'b1;
          e_kind    = KIND_FIRED;
          e_over    = alu_res.diff[30:0];
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_ARM_FIND;
        end
      end

      ST_ARM_FIND: begin
        if (!live_r[scan_r]) begin
          rem_we           = 1'b1;
          rem_wa           = scan_r;
          rem_wd           = acc_r[30:0];
          id_we            = 1'b1;
          live_nxt[scan_r] = 1'b1;
          next_id_nxt      = next_id_r + 1'b1;
          e_valid          = 1'b1;
          e_kind           = KIND_ARMED;
          e_id             = next_id_x[15:0];
          state_nxt        = ST_IDLE;
        end else if (scan_r == LAST_SLOT) begin
          e_valid   = 1'b1;
          e_kind    = KIND_FULL;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      ST_CLR: begin
        pend_nxt = issue_r;
        pidx_nxt = scan_r;
        if (issue_r) begin
          if (scan_r == LAST_SLOT) issue_nxt = 1'b0;
          else scan_nxt = scan_r + 1'b1;
        end
        if (pend_r && live_r[pidx_r] && (rd_id_r == tid_r)) begin
          live_nxt[pidx_r] = 1'b0;
          e_valid          = 1'b1;
          e_kind           = KIND_CLEARED;
          e_id             = tid_r_x[15:0];
          issue_nxt        = 1'b0;
          pend_nxt         = 1'b0;
          state_nxt        = ST_IDLE;
        end else if (!issue_r && !pend_r) begin
          e_valid   = 1'b1;
          e_kind    = KIND_NOT_FOUND;
          e_id      = tid_r_x[15:0];
          state_nxt = ST_IDLE;
        end
      end

      ST_SETC: begin
        e_valid   = 1'b1;
        state_nxt = ST_IDLE;
        if (own_ok_r) begin
          cr_we                  = 1'b1;
          cr_wd                  = amount_r;
          present_nxt[own_idx_r] = 1'b1;
          e_kind                 = KIND_CREDIT;
          e_cred                 = amount_r;
        end else begin
          e_kind = KIND_NO_CREDIT;
        end
      end

      ST_RDC_A: state_nxt = ST_RDC_B;

      ST_RDC_B: begin
        e_valid   = 1'b1;
        state_nxt = ST_IDLE;
        if (own_ok_r && present_r[own_idx_r]) begin
          e_kind = KIND_CREDIT;
          e_cred = rd_cr_r;
        end else begin
          e_kind = KIND_NO_CREDIT;
        end
      end

      ST_DFLT: begin
        e_valid   = 1'b1;
        e_kind    = KIND_DONE;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      pidx_r      <= '0;
      wb_en_r     <= 1'b0;
      wb_idx_r    <= '0;
      acc_r       <= '0;
      next_id_r   <= '0;
      live_r      <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      pidx_r      <= pidx_nxt;
      wb_en_r     <= wb_en_nxt;
      wb_idx_r    <= wb_idx_nxt;
      acc_r       <= acc_nxt;
      next_id_r   <= next_id_nxt;
      live_r      <= live_nxt;
      present_r   <= present_nxt;
      out_valid_r <= e_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wb_d_r             <= wb_d_nxt;
    out_kind_r         <= e_kind;
    out_result_id_r    <= e_id;
    out_overshoot_r    <= e_over;
    out_credit_value_r <= e_cred;
    out_last_r         <= e_last;
    if (accept) begin
      amount_r  <= in_amount;
      carry_r   <= in_carry_in;
      ownv_r    <= in_owner_valid;
      own_idx_r <= own_x[OA-1:0];
      own_ok_r  <= (own_x < 9'(OWNER_SLOTS));
      tid_r     <= tid_x[ID_BITS-1:0];
    end
  end

  // slot memories: one write port, read at the scan index
  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (id_we) id_mem[scan_r] <= next_id_r;
    rd_rem_r <= rem_mem[scan_r];
    rd_id_r  <= id_mem[scan_r];
  end

  // credit memory: read and written at the captured owner
  always_ff @(posedge clk) begin
    if (cr_we) cr_mem[own_idx_r] <= cr_wd;
    rd_cr_r <= cr_mem[own_idx_r];
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_result_id    = out_result_id_r;
  assign out_overshoot    = out_overshoot_r;
  assign out_credit_value = out_credit_value_r;
  assign out_last         = out_last_r;

endmodule

FILE: tb/sv/tpoc_tb_pkg.sv
// Transaction types and the scoreboard that shadows the timer pool and its owner credit.
package tpoc_tb_pkg;
  import tpoc_pkg::*;

  typedef struct {
    logic [2:0]  func;
    logic [30:0] amount;
    logic [30:0] carry;
    logic        owner_valid;
    logic [3:0]  owner;
    logic [15:0] timer_id;
  } tpoc_request_t;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] result_id;
    logic [30:0] overshoot;
    logic [30:0] credit_value;
    logic        last;
  } tpoc_result_t;

  class timer_pool_shadow;
    bit          slot_live[TIMER_SLOTS_DEF];
    logic [31:0] slot_left[TIMER_SLOTS_DEF];
    logic [15:0] slot_ident[TIMER_SLOTS_DEF];
    logic [15:0] next_ident;
    bit          credit_held[OWNER_SLOTS_DEF];
    logic [31:0] credit_amount[OWNER_SLOTS_DEF];

    tpoc_result_t pending_results[$];
    int           mismatches;
    int           results_seen;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i]  = 1'b0;
        slot_left[i]  = '0;
        slot_ident[i] = '0;
      end
      foreach (credit_held[i]) begin
        credit_held[i]   = 1'b0;
        credit_amount[i] = '0;
      end
      next_ident   = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void queue_result(kind_t kind, logic [15:0] id, longint over, longint credit,
                               bit last);
      tpoc_result_t r;
      r.kind         = kind;
      r.result_id    = id;
      r.overshoot    = over[30:0];
      r.credit_value = credit[30:0];
      r.last         = last;
      pending_results.push_back(r);
    endfunction

    // Advance the shadow state by one accepted transaction and queue its results.
    function void take_request(tpoc_request_t rq);
      longint amount_l;
      longint carry_l;
      longint rem;
      longint dur;
      longint cr;
      longint left;
      int     slot;
      bit     owner_ok;
      amount_l = longint'(rq.amount);
      carry_l  = longint'(rq.carry);
      owner_ok = int'(rq.owner) < OWNER_SLOTS_DEF;
      case (rq.func)
        FUNC_TICK: begin
          for (int i = TIMER_SLOTS_DEF - 1; i >= 0; i--) begin
            if (slot_live[i]) begin
              rem = longint'(slot_left[i]) - amount_l;
              if (rem <= 0) begin
                queue_result(KIND_EXPIRED, slot_ident[i], -rem, 0, 1'b0);
                slot_live[i] = 1'b0;
              end else begin
                slot_left[i] = rem[31:0];
              end
            end
          end
          queue_result(KIND_DONE, '0, 0, 0, 1'b1);
        end
        FUNC_ARM: begin
          dur  = amount_l - carry_l;
          slot = -1;
          if (rq.owner_valid && owner_ok && credit_held[rq.owner]) begin
            cr = longint'(credit_amount[rq.owner]);
            if (cr <= dur) begin
              dur -= cr;
              credit_held[rq.owner] = 1'b0;
            end else begin
              // credit outlasts the duration: shrink it, saturating, and fire now
              left = cr - dur;
              if (left > longint'(MAX31)) left = longint'(MAX31);
              credit_amount[rq.owner] = left[31:0];
              queue_result(KIND_FIRED, '0, 0, 0, 1'b1);
              return;
            end
          end
          if (dur < 0) begin
            queue_result(KIND_FIRED, '0, -dur, 0, 1'b1);
            return;
          end
          for (int i = 0; i < TIMER_SLOTS_DEF && slot < 0; i++) begin
            if (!slot_live[i]) slot = i;
          end
          if (slot < 0) begin
            queue_result(KIND_FULL, '0, 0, 0, 1'b1);
            return;
          end
          slot_live[slot]  = 1'b1;
          slot_left[slot]  = dur[31:0];
          slot_ident[slot] = next_ident;
          queue_result(KIND_ARMED, next_ident, 0, 0, 1'b1);
          next_ident = next_ident + 16'd1;
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < TIMER_SLOTS_DEF; i++) begin
            if (slot_live[i] && slot_ident[i] == rq.timer_id) begin
              slot_live[i] = 1'b0;
              queue_result(KIND_CLEARED, rq.timer_id, 0, 0, 1'b1);
              return;
            end
          end
          queue_result(KIND_NOT_FOUND, rq.timer_id, 0, 0, 1'b1);
        end
        FUNC_SETCR: begin
          if (!owner_ok) begin
            queue_result(KIND_NO_CREDIT, '0, 0, 0, 1'b1);
          end else begin
            credit_held[rq.owner]   = 1'b1;
            credit_amount[rq.owner] = {1'b0, rq.amount};
            queue_result(KIND_CREDIT, '0, 0, amount_l, 1'b1);
          end
        end
        FUNC_RDCR: begin
          if (owner_ok && credit_held[rq.owner])
            queue_result(KIND_CREDIT, '0, 0, longint'(credit_amount[rq.owner]), 1'b1);
          else
            queue_result(KIND_NO_CREDIT, '0, 0, 0, 1'b1);
        end
        default: begin
          queue_result(KIND_DONE, '0, 0, 0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch on result %0d: %s", results_seen, msg);
    endtask

    task match_result(tpoc_result_t got);
      tpoc_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, kind %0d id %0h",
                                  got.kind, got.result_id));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.result_id !== want.result_id)
        report_mismatch($sformatf("result_id %0h, want %0h", got.result_id, want.result_id));
      if (got.overshoot !== want.overshoot)
        report_mismatch($sformatf("overshoot %0h, want %0h", got.overshoot, want.overshoot));
      if (got.credit_value !== want.credit_value)
        report_mismatch($sformatf("credit_value %0h, want %0h",
                                  got.credit_value, want.credit_value));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

endpackage

FILE: tb/sv/timer_pool_with_owner_credit_top_test.sv
// Testbench top: drives directed and random requests into the timer pool and checks results.
module timer_pool_with_owner_credit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpoc_pkg::*;
  import tpoc_tb_pkg::*;

  localparam int RANDOM_ITEMS = 355;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 40;

  localparam int PROF_MIX    = 0;
  localparam int PROF_FILL   = 1;
  localparam int PROF_DRAIN  = 2;
  localparam int PROF_CREDIT = 3;
  localparam int PROF_NOISE  = 4;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [2:0]  in_func        = '0;
  logic [30:0] in_amount      = '0;
  logic [30:0] in_carry_in    = '0;
  logic        in_owner_valid = 1'b0;
  logic [3:0]  in_owner       = '0;
  logic [15:0] in_timer_id    = '0;

  logic        busy;
  logic        out_valid;
  logic [3:0]  out_kind;
  logic [15:0] out_result_id;
  logic [30:0] out_overshoot;
  logic [30:0] out_credit_value;
  logic        out_last;

  timer_pool_shadow shadow;
  int               idle_cycles = 0;

  timer_pool_with_owner_credit_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_amount       (in_amount),
    .in_carry_in     (in_carry_in),
    .in_owner_valid  (in_owner_valid),
    .in_owner        (in_owner),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_result_id   (out_result_id),
    .out_overshoot   (out_overshoot),
    .out_credit_value(out_credit_value),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    tpoc_result_t got;
    if (rst_n && out_valid) begin
      got.kind         = out_kind;
      got.result_id    = out_result_id;
      got.overshoot    = out_overshoot;
      got.credit_value = out_credit_value;
      got.last         = out_last;
      shadow.match_result(got);
    end
  end

  // Restart the count on any transaction in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** timer_pool_with_owner_credit_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [30:0] pick_time();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 60) return 31'($urandom_range(0, 'h30000));
    if (r < 85) return 31'($urandom_range(0, 'hFF_FFFF));
    if (r < 95) return raw[30:0];
    return raw[0] ? MAX31 : '0;
  endfunction

  function automatic logic [30:0] pick_carry();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 60) return '0;
    if (r < 90) return 31'($urandom_range(0, 'h8000));
    return raw[30:0];
  endfunction

  function automatic tpoc_request_t make_req(int profile);
    tpoc_request_t rq;
    logic [31:0]   raw;
    int            r;
    int            lim_tick;
    int            lim_arm;
    int            lim_clr;
    int            lim_set;
    rq.amount      = pick_time();
    rq.carry       = pick_carry();
    rq.owner       = 4'($urandom_range(0, 15));
    rq.owner_valid = 1'($urandom_range(0, 1));
    raw            = $urandom();
    rq.timer_id    = raw[15:0];
    rq.func        = FUNC_TICK;
    if (profile == PROF_NOISE) begin
      raw       = $urandom();
      rq.func   = raw[2:0];
      raw       = $urandom();
      rq.amount = raw[30:0];
      raw       = $urandom();
      rq.carry  = raw[30:0];
      return rq;
    end
    // cumulative thresholds out of 100; read credit takes the rest
    case (profile)
      PROF_FILL: begin
        lim_tick = 5;  lim_arm = 85; lim_clr = 90; lim_set = 95;
      end
      PROF_DRAIN: begin
        lim_tick = 50; lim_arm = 75; lim_clr = 95; lim_set = 97;
      end
      PROF_CREDIT: begin
        lim_tick = 10; lim_arm = 45; lim_clr = 50; lim_set = 75;
      end
      default: begin
        lim_tick = 25; lim_arm = 60; lim_clr = 75; lim_set = 87;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < lim_tick)     rq.func = FUNC_TICK;
    else if (r < lim_arm) rq.func = FUNC_ARM;
    else if (r < lim_clr) rq.func = FUNC_CLEAR;
    else if (r < lim_set) rq.func = FUNC_SETCR;
    else                  rq.func = FUNC_RDCR;
    // aim most clears at recently issued identifiers so some hit a live slot
    if (rq.func == FUNC_CLEAR && $urandom_range(0, 99) < 65)
      rq.timer_id = shadow.next_ident - 16'($urandom_range(1, 24));
    if (profile == PROF_CREDIT && rq.func == FUNC_ARM) rq.owner_valid = 1'b1;
    return rq;
  endfunction

  task automatic send_req(tpoc_request_t rq);
    start          <= 1'b1;
    in_func        <= rq.func;
    in_amount      <= rq.amount;
    in_carry_in    <= rq.carry;
    in_owner_valid <= rq.owner_valid;
    in_owner       <= rq.owner;
    in_timer_id    <= rq.timer_id;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.take_request(rq);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold the sender until every queued result has come back.
  task automatic hold_until_drained();
    if (shadow.outstanding() != 0) begin
      start <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clk);
    end
  endtask

  task automatic directed(logic [2:0] func, logic [30:0] amount, logic [30:0] carry,
                          logic owner_valid, logic [3:0] owner, logic [15:0] timer_id);
    tpoc_request_t rq;
    rq.func        = func;
    rq.amount      = amount;
    rq.carry       = carry;
    rq.owner_valid = owner_valid;
    rq.owner       = owner;
    rq.timer_id    = timer_id;
    send_req(rq);
    idle_gap(pick_gap());
  endtask

  initial begin
    int sent;
    int profile;
    int run;
    int r;
    bit gaps_on;
    shadow = new();
    sent   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty pool and missing credit
    directed(FUNC_RDCR, '0, '0, 1'b0, 4'd0, '0);
    directed(FUNC_TICK, '0, '0, 1'b0, 4'd0, '0);
    directed(FUNC_CLEAR, '0, '0, 1'b0, 4'd0, 16'hFFFF);
    directed(FUNC_ARM, 31'h1_0000, '0, 1'b0, 4'd0, '0);
    directed(FUNC_ARM, MAX31, '0, 1'b0, 4'd0, '0);
    // negative durations fire at once with the overshoot
    directed(FUNC_ARM, 31'd5, 31'd10, 1'b0, 4'd0, '0);
    directed(FUNC_ARM, '0, MAX31, 1'b0, 4'd0, '0);
    // credit below and equal to the duration is consumed
    directed(FUNC_SETCR, 31'h8000, '0, 1'b0, 4'd15, '0);
    directed(FUNC_ARM, 31'h1_8000, '0, 1'b1, 4'd15, '0);
    directed(FUNC_RDCR, '0, '0, 1'b0, 4'd15, '0);
    directed(FUNC_SETCR, 31'h4000, '0, 1'b0, 4'd6, '0);
    directed(FUNC_ARM, 31'h4000, '0, 1'b1, 4'd6, '0);
    // credit growth saturates
    directed(FUNC_SETCR, MAX31, '0, 1'b0, 4'd3, '0);
    directed(FUNC_ARM, '0, 31'd7, 1'b1, 4'd3, '0);
    directed(FUNC_RDCR, '0, '0, 1'b0, 4'd3, '0);
    // credit ignored without owner_valid, then fires the timer
    directed(FUNC_SETCR, 31'h2_0000, '0, 1'b0, 4'd4, '0);
    directed(FUNC_ARM, 31'h1000, '0, 1'b0, 4'd4, '0);
    directed(FUNC_ARM, 31'h1000, '0, 1'b1, 4'd4, '0);
    directed(FUNC_RDCR, '0, '0, 1'b0, 4'd4, '0);
    directed(FUNC_TICK, 31'h1_0000, '0, 1'b0, 4'd0, '0);
    directed(FUNC_CLEAR, '0, '0, 1'b0, 4'd0, 16'd1);
    directed(FUNC_CLEAR, '0, '0, 1'b0, 4'd0, 16'd1);
    // unknown codes
    directed(3'd5, MAX31, MAX31, 1'b1, 4'd15, 16'hFFFF);
    directed(3'd6, MAX31, MAX31, 1'b1, 4'd15, 16'hFFFF);
    directed(3'd7, MAX31, MAX31, 1'b1, 4'd15, 16'hFFFF);

    hold_until_drained();

    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30)      profile = PROF_MIX;
      else if (r < 50) profile = PROF_FILL;
      else if (r < 70) profile = PROF_DRAIN;
      else if (r < 88) profile = PROF_CREDIT;
      else             profile = PROF_NOISE;
      run     = $urandom_range(10, 40);
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
        send_req(make_req(profile));
        sent++;
        if (gaps_on) idle_gap(pick_gap());
      end
    end

    start <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("** timer_pool_with_owner_credit_top: PASSED **");
    else
      $display("** timer_pool_with_owner_credit_top: FAILED **");
    $finish;
  end

endmodule
